[sv/assert_macros.svh]
// assertion macros shared by the chord length modules
// no dependencies; clock i_clk and active-low reset i_rst_n are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCC_ASSERT_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("implication check failed");
`define RCC_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("next cycle check failed");
`else
`define RCC_ASSERT_IMPLY(lbl, a, c)
`define RCC_ASSERT_NEXT(lbl, a, c)
`endif
`endif

[sv/rcc_pkg.sv]
// shared constants and types for the ray circle chord length block
// no dependencies
package rcc_pkg;

    // default coordinate width in bits
    localparam int COORD_WIDTH_DEF = 24;

    // control flags that travel with each item down the cell chain
    typedef struct packed {
        logic valid;
        logic hit;
        logic degen;
    } t_ctl;

endpackage

[sv/rcc_div_cell.sv]
// one restoring division cell: decides one quotient bit of 4*M / D
// depends on rcc_pkg and assert_macros.svh
`include "assert_macros.svh"
module rcc_div_cell #(
    parameter int COORD_WIDTH = rcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rcc_pkg::t_ctl               i_ctl,
    input  logic [2*COORD_WIDTH+2:0]    i_rem,
    input  logic [2*COORD_WIDTH-1:0]    i_low,
    input  logic [2*COORD_WIDTH-1:0]    i_quot,
    input  logic [2*COORD_WIDTH+1:0]    i_d,
    output rcc_pkg::t_ctl               o_ctl,
    output logic [2*COORD_WIDTH+2:0]    o_rem,
    output logic [2*COORD_WIDTH-1:0]    o_low,
    output logic [2*COORD_WIDTH-1:0]    o_quot,
    output logic [2*COORD_WIDTH+1:0]    o_d
);
    import rcc_pkg::*;

    localparam int DW = 2*COORD_WIDTH + 2;
    localparam int RW = DW + 1;
    localparam int QW = 2*COORD_WIDTH;

    logic [RW-1:0] w_trial;
    logic          w_ge;
    t_ctl          r_ctl, n_ctl;
    logic [RW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_low, n_low;
    logic [QW-1:0] r_quot, n_quot;
    logic [DW-1:0] r_d;

    // shift in next numerator bit, subtract divisor when it fits
    always_comb begin
        w_trial = {i_rem[RW-2:0], i_low[QW-1]};
        w_ge    = (w_trial >= (RW)'(i_d));
        n_rem   = w_ge ? (w_trial - (RW)'(i_d)) : w_trial;
        n_low   = {i_low[QW-2:0], 1'b0};
        n_quot  = {i_quot[QW-2:0], w_ge};
        n_ctl   = i_ctl;
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_d    <= i_d;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_quot = r_quot;
    assign o_d    = r_d;

    `RCC_ASSERT_IMPLY(a_rem_below_d, r_ctl.valid && r_ctl.hit, r_rem < (RW)'(r_d))
    `RCC_ASSERT_NEXT(a_valid_moves, i_ctl.valid, r_ctl.valid)
    `RCC_ASSERT_IMPLY(a_miss_zero_rem, r_ctl.valid && !r_ctl.hit, r_rem == '0)

endmodule

[sv/rcc_sqrt_cell.sv]
// one digit-by-digit square root cell: decides one root bit
// depends on rcc_pkg and assert_macros.svh
`include "assert_macros.svh"
module rcc_sqrt_cell #(
    parameter int COORD_WIDTH = rcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rcc_pkg::t_ctl               i_ctl,
    input  logic [COORD_WIDTH+1:0]      i_rem,
    input  logic [COORD_WIDTH-1:0]      i_root,
    input  logic [2*COORD_WIDTH-1:0]    i_rest,
    output rcc_pkg::t_ctl               o_ctl,
    output logic [COORD_WIDTH+1:0]      o_rem,
    output logic [COORD_WIDTH-1:0]      o_root,
    output logic [2*COORD_WIDTH-1:0]    o_rest
);
    import rcc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int RW = W + 2;

    logic [RW-1:0]  w_acc;
    logic [RW-1:0]  w_trial;
    logic           w_ge;
    t_ctl           r_ctl, n_ctl;
    logic [RW-1:0]  r_rem, n_rem;
    logic [W-1:0]   r_root, n_root;
    logic [2*W-1:0] r_rest, n_rest;

    // bring down two radicand bits and try root bit one
    always_comb begin
        w_acc   = {i_rem[W-1:0], i_rest[2*W-1 -: 2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_acc >= w_trial);
        n_rem   = w_ge ? (w_acc - w_trial) : w_acc;
        n_root  = {i_root[W-2:0], w_ge};
        n_rest  = {i_rest[2*W-3:0], 2'b00};
        n_ctl   = i_ctl;
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rest <= n_rest;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rest = r_rest;

    `RCC_ASSERT_IMPLY(a_rem_bound, r_ctl.valid, r_rem <= {1'b0, r_root, 1'b0})
    `RCC_ASSERT_NEXT(a_valid_moves, i_ctl.valid, r_ctl.valid)
    `RCC_ASSERT_IMPLY(a_miss_zero_root, r_ctl.valid && !r_ctl.hit, r_root == '0)

endmodule

[sv/ray_circle_chord_length.sv]
// ray circle chord length: front pipeline, divider cell chain, root cell chain
// depends on rcc_pkg, rcc_div_cell, rcc_sqrt_cell and assert_macros.svh
// throughput: one item per cycle; busy is always low, each cell takes a new item every cycle
// the chain length is set by one cell per quotient bit and one cell per root bit
// reset: synchronous active-low i_rst_n clears all valid flags; results never stall
`include "assert_macros.svh"
module ray_circle_chord_length #(
    parameter int COORD_WIDTH = rcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]  i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]  i_target_x,
    input  logic signed [COORD_WIDTH-1:0]  i_target_y,
    input  logic signed [COORD_WIDTH-1:0]  i_center_x,
    input  logic signed [COORD_WIDTH-1:0]  i_center_y,
    input  logic        [COORD_WIDTH-2:0]  i_radius,
    output logic                           o_valid,
    output logic        [COORD_WIDTH:0]    o_chord_length,
    output logic                           o_hit,
    output logic                           o_degenerate
);
    import rcc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int SW  = W + 1;        // coordinate differences
    localparam int PW  = 2*W + 2;      // products of differences
    localparam int CW3 = 2*W + 3;      // signed cross product
    localparam int DW  = 2*W + 2;      // |d|^2 and |C|
    localparam int H   = W + 1;        // half split for wide products
    localparam int MW  = 2*DW;         // R^2*D, C^2, 4*M
    localparam int QW  = 2*W;          // quotient bits
    localparam int RW  = DW + 1;       // divider remainder
    localparam int R2W = 2*W - 2;      // radius squared

    // stage 1: differences
    t_ctl                 r1_ctl;
    logic signed [SW-1:0] r1_dx, r1_dy, r1_vx, r1_vy;
    logic        [W-2:0]  r1_rad;
    // stage 2: small products
    t_ctl                 r2_ctl;
    logic signed [PW-1:0] r2_dxx, r2_dyy, r2_a, r2_b;
    logic        [R2W-1:0] r2_r2;
    // stage 3: D and |C|
    t_ctl                 r3_ctl;
    logic        [DW-1:0] r3_d, r3_c, n3_c;
    logic signed [CW3-1:0] w3_cdiff;
    logic        [R2W-1:0] r3_r2;
    // stage 4: partial products
    t_ctl                 r4_ctl;
    logic        [2*H-1:0] r4_cc_hh, r4_cc_hl, r4_cc_ll;
    logic        [2*H-1:0] r4_rd_hh, r4_rd_hl, r4_rd_lh, r4_rd_ll;
    logic        [DW-1:0] r4_d, w4_r2e;
    // stage 5: R^2*D and C^2
    t_ctl                 r5_ctl;
    logic        [MW-1:0] r5_rd, r5_c2;
    logic        [DW-1:0] r5_d;
    // stage 6: numerator 4*M
    t_ctl                 r6_ctl, n6_ctl;
    logic        [MW-1:0] r6_num, n6_num;
    logic        [DW-1:0] r6_d;

    // front control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
        end else begin
            r1_ctl <= '{valid: start, hit: 1'b0, degen: 1'b0};
            r2_ctl <= '{valid: r1_ctl.valid, hit: 1'b0,
                        degen: (r1_dx == '0) && (r1_dy == '0)};
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= n6_ctl;
        end
    end

    // cross product sign handling and hit decision
    always_comb begin
        w3_cdiff = (CW3)'(r2_a) - (CW3)'(r2_b);
        n3_c     = w3_cdiff[CW3-1] ? DW'(-w3_cdiff) : DW'(w3_cdiff);
        w4_r2e   = (DW)'(r3_r2);
        n6_ctl   = r5_ctl;
        n6_ctl.hit = (r5_rd > r5_c2) && !r5_ctl.degen;
        n6_num   = n6_ctl.hit ? ((r5_rd - r5_c2) << 2) : '0;
    end

    // front datapath registers
    always_ff @(posedge i_clk) begin
        r1_dx  <= (SW)'(i_target_x) - (SW)'(i_origin_x);
        r1_dy  <= (SW)'(i_target_y) - (SW)'(i_origin_y);
        r1_vx  <= (SW)'(i_center_x) - (SW)'(i_origin_x);
        r1_vy  <= (SW)'(i_center_y) - (SW)'(i_origin_y);
        r1_rad <= i_radius;

        r2_dxx <= r1_dx * r1_dx;
        r2_dyy <= r1_dy * r1_dy;
        r2_a   <= r1_vx * r1_dy;
        r2_b   <= r1_vy * r1_dx;
        r2_r2  <= r1_rad * r1_rad;

        r3_d   <= DW'(r2_dxx + r2_dyy);
        r3_c   <= n3_c;
        r3_r2  <= r2_r2;

        r4_cc_hh <= r3_c[DW-1:H] * r3_c[DW-1:H];
        r4_cc_hl <= r3_c[DW-1:H] * r3_c[H-1:0];
        r4_cc_ll <= r3_c[H-1:0]  * r3_c[H-1:0];
        r4_rd_hh <= w4_r2e[DW-1:H] * r3_d[DW-1:H];
        r4_rd_hl <= w4_r2e[DW-1:H] * r3_d[H-1:0];
        r4_rd_lh <= w4_r2e[H-1:0]  * r3_d[DW-1:H];
        r4_rd_ll <= w4_r2e[H-1:0]  * r3_d[H-1:0];
        r4_d     <= r3_d;

        r5_c2 <= {r4_cc_hh, r4_cc_ll} + ((MW)'(r4_cc_hl) << (H + 1));
        r5_rd <= {r4_rd_hh, r4_rd_ll} + ((MW)'(r4_rd_hl) << H)
                 + ((MW)'(r4_rd_lh) << H);
        r5_d  <= r4_d;

        r6_num <= n6_num;
        r6_d   <= r5_d;
    end

    // divider chain: one quotient bit per cell
    t_ctl          w_dctl [0:QW];
    logic [RW-1:0] w_drem [0:QW];
    logic [QW-1:0] w_dlow [0:QW];
    logic [QW-1:0] w_dquo [0:QW];
    logic [DW-1:0] w_dd   [0:QW];

    assign w_dctl[0] = r6_ctl;
    assign w_drem[0] = r6_num[QW+RW-1:QW];
    assign w_dlow[0] = r6_num[QW-1:0];
    assign w_dquo[0] = '0;
    assign w_dd[0]   = r6_d;

    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        rcc_div_cell #(.COORD_WIDTH(W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_dctl[gi]),
            .i_rem  (w_drem[gi]),
            .i_low  (w_dlow[gi]),
            .i_quot (w_dquo[gi]),
            .i_d    (w_dd[gi]),
            .o_ctl  (w_dctl[gi+1]),
            .o_rem  (w_drem[gi+1]),
            .o_low  (w_dlow[gi+1]),
            .o_quot (w_dquo[gi+1]),
            .o_d    (w_dd[gi+1])
        );
    end

    // root chain: one root bit per cell; the quotient of a miss or a zero divisor is masked
    t_ctl           w_sctl  [0:W];
    logic [W+1:0]   w_srem  [0:W];
    logic [W-1:0]   w_sroot [0:W];
    logic [2*W-1:0] w_srest [0:W];

    assign w_sctl[0]  = w_dctl[QW];
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srest[0] = w_dctl[QW].hit ? w_dquo[QW] : '0;

    for (genvar gj = 0; gj < W; gj++) begin : g_sqrt
        rcc_sqrt_cell #(.COORD_WIDTH(W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_sctl[gj]),
            .i_rem  (w_srem[gj]),
            .i_root (w_sroot[gj]),
            .i_rest (w_srest[gj]),
            .o_ctl  (w_sctl[gj+1]),
            .o_rem  (w_srem[gj+1]),
            .o_root (w_sroot[gj+1]),
            .o_rest (w_srest[gj+1])
        );
    end

    // result ports
    assign busy           = 1'b0;
    assign o_valid        = w_sctl[W].valid;
    assign o_hit          = w_sctl[W].hit;
    assign o_degenerate   = w_sctl[W].degen;
    assign o_chord_length = {1'b0, w_sroot[W]};

    `RCC_ASSERT_IMPLY(a_degen_zero, o_valid && o_degenerate, o_chord_length == '0 && !o_hit)
    `RCC_ASSERT_IMPLY(a_miss_zero, o_valid && !o_hit, o_chord_length == '0)
    `RCC_ASSERT_IMPLY(a_hit_num, r6_ctl.valid && r6_ctl.hit, r6_num != '0)

endmodule
